// ----- hw/rtl/sid_pkg.sv -----
`default_nettype none

package sid_pkg;

  // coordinate width, signed q7.8 at the default
  localparam int COORD_WIDTH = 16;
  localparam int CW = COORD_WIDTH;
  // signed difference of two coordinates
  localparam int UW = CW + 1;
  // signed product of two differences
  localparam int PW = 2 * UW;
  // signed cross product
  localparam int XW = PW + 1;
  // magnitude of a cross product
  localparam int MW = XW - 1;
  // split of the numerator magnitude for the partial products
  localparam int HW = (MW + 1) / 2;
  localparam int LW = CW + HW;
  localparam int GW = CW + MW - HW;
  // dividend width and quotient bits, one quotient bit per cell
  localparam int NW = CW + MW;
  localparam int QB = CW;
  // tolerance register width
  localparam int TW = 16;

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } sid_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } sid_out_t;

  // what one divider cell hands to the next
  typedef struct packed {
    logic          vld;
    logic          hit;
    logic          negx;
    logic          negy;
    logic [CW-1:0] p1x;
    logic [CW-1:0] p1y;
    logic [MW-1:0] dmag;
    logic [MW-1:0] remx;
    logic [QB-1:0] lqx;
    logic [MW-1:0] remy;
    logic [QB-1:0] lqy;
  } sid_cell_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sid_front.sv -----
`default_nettype none

module sid_front
  import sid_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    in_vld,
  input  wire sid_in_t in_data,
  input  wire [TW-1:0] tol,
  output sid_cell_t    cell_o
);

  logic [5:0] vld_r;

  // stage 1: differences
  logic signed [UW-1:0] ux_r, uy_r, vx_r, vy_r, wx_r, wy_r;
  logic signed [UW-1:0] ux_nxt, uy_nxt, vx_nxt, vy_nxt, wx_nxt, wy_nxt;
  logic [CW-1:0]        p1x1_r, p1y1_r;

  // stage 2: products
  logic signed [PW-1:0] uxvy_r, uyvx_r, vxwy_r, vywx_r, uxwy_r, uywx_r;
  logic signed [PW-1:0] uxvy_nxt, uyvx_nxt, vxwy_nxt, vywx_nxt, uxwy_nxt, uywx_nxt;
  logic signed [UW-1:0] ux2_r, uy2_r;
  logic [CW-1:0]        p1x2_r, p1y2_r;

  // stage 3: cross products
  logic signed [XW-1:0] d_r, n_r, m_r;
  logic signed [XW-1:0] d_nxt, n_nxt, m_nxt;
  logic signed [UW-1:0] ux3_r, uy3_r;
  logic [CW-1:0]        p1x3_r, p1y3_r;

  // stage 4: range checks and magnitudes
  logic                 hit4_r, hit4_nxt;
  logic [MW-1:0]        dmag4_r, dmag4_nxt, nmag_r, nmag_nxt;
  logic [CW-1:0]        uxmag_r, uxmag_nxt, uymag_r, uymag_nxt;
  logic                 negx4_r, negx4_nxt, negy4_r, negy4_nxt;
  logic [CW-1:0]        p1x4_r, p1y4_r;
  logic signed [XW-1:0] d_neg, n_neg;
  logic signed [UW-1:0] ux_neg, uy_neg;
  logic                 par, n_ok, m_ok;

  // stage 5: partial products of the dividends
  logic [LW-1:0]        pxl_r, pxl_nxt, pyl_r, pyl_nxt;
  logic [GW-1:0]        pxh_r, pxh_nxt, pyh_r, pyh_nxt;
  logic                 hit5_r, negx5_r, negy5_r;
  logic [MW-1:0]        dmag5_r;
  logic [CW-1:0]        p1x5_r, p1y5_r;

  // stage 6: dividend assembled, loaded into the first cell's form
  sid_cell_t            cell_r, cell_nxt;
  logic [NW-1:0]        nx, ny;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_comb begin
    ux_nxt = UW'(in_data.a_end_x) - UW'(in_data.a_start_x);
    uy_nxt = UW'(in_data.a_end_y) - UW'(in_data.a_start_y);
    vx_nxt = UW'(in_data.b_end_x) - UW'(in_data.b_start_x);
    vy_nxt = UW'(in_data.b_end_y) - UW'(in_data.b_start_y);
    wx_nxt = UW'(in_data.a_start_x) - UW'(in_data.b_start_x);
    wy_nxt = UW'(in_data.a_start_y) - UW'(in_data.b_start_y);
  end

  always_comb begin
    uxvy_nxt = ux_r * vy_r;
    uyvx_nxt = uy_r * vx_r;
    vxwy_nxt = vx_r * wy_r;
    vywx_nxt = vy_r * wx_r;
    uxwy_nxt = ux_r * wy_r;
    uywx_nxt = uy_r * wx_r;
  end

  always_comb begin
    d_nxt = XW'(uxvy_r) - XW'(uyvx_r);
    n_nxt = XW'(vxwy_r) - XW'(vywx_r);
    m_nxt = XW'(uxwy_r) - XW'(uywx_r);
  end

  always_comb begin
    d_neg  = -d_r;
    n_neg  = -n_r;
    ux_neg = -ux3_r;
    uy_neg = -uy3_r;
    dmag4_nxt = d_r[XW-1] ? d_neg[MW-1:0] : d_r[MW-1:0];
    nmag_nxt  = n_r[XW-1] ? n_neg[MW-1:0] : n_r[MW-1:0];
    uxmag_nxt = ux3_r[UW-1] ? ux_neg[CW-1:0] : ux3_r[CW-1:0];
    uymag_nxt = uy3_r[UW-1] ? uy_neg[CW-1:0] : uy3_r[CW-1:0];
    par = dmag4_nxt <= MW'(tol);
    // parameter in [0,1] without dividing, by the sign of d
    if (!d_r[XW-1]) begin
      n_ok = !n_r[XW-1] && (n_r <= d_r);
      m_ok = !m_r[XW-1] && (m_r <= d_r);
    end else begin
      n_ok = (n_r[XW-1] || n_r == '0) && (n_r >= d_r);
      m_ok = (m_r[XW-1] || m_r == '0) && (m_r >= d_r);
    end
    hit4_nxt  = !par && n_ok && m_ok;
    negx4_nxt = ux3_r[UW-1] ^ n_r[XW-1] ^ d_r[XW-1];
    negy4_nxt = uy3_r[UW-1] ^ n_r[XW-1] ^ d_r[XW-1];
  end

  always_comb begin
    pxl_nxt = LW'(uxmag_r) * LW'(nmag_r[HW-1:0]);
    pxh_nxt = GW'(uxmag_r) * GW'(nmag_r[MW-1:HW]);
    pyl_nxt = LW'(uymag_r) * LW'(nmag_r[HW-1:0]);
    pyh_nxt = GW'(uymag_r) * GW'(nmag_r[MW-1:HW]);
  end

  always_comb begin
    nx = NW'(pxl_r) + (NW'(pxh_r) << HW);
    ny = NW'(pyl_r) + (NW'(pyh_r) << HW);
    cell_nxt.vld  = vld_r[4];
    cell_nxt.hit  = hit5_r;
    cell_nxt.negx = negx5_r;
    cell_nxt.negy = negy5_r;
    cell_nxt.p1x  = p1x5_r;
    cell_nxt.p1y  = p1y5_r;
    cell_nxt.dmag = dmag5_r;
    cell_nxt.remx = nx[NW-1:QB];
    cell_nxt.lqx  = nx[QB-1:0];
    cell_nxt.remy = ny[NW-1:QB];
    cell_nxt.lqy  = ny[QB-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r   <= ux_nxt;
      uy_r   <= uy_nxt;
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      wx_r   <= wx_nxt;
      wy_r   <= wy_nxt;
      p1x1_r <= in_data.a_start_x;
      p1y1_r <= in_data.a_start_y;

      uxvy_r <= uxvy_nxt;
      uyvx_r <= uyvx_nxt;
      vxwy_r <= vxwy_nxt;
      vywx_r <= vywx_nxt;
      uxwy_r <= uxwy_nxt;
      uywx_r <= uywx_nxt;
      ux2_r  <= ux_r;
      uy2_r  <= uy_r;
      p1x2_r <= p1x1_r;
      p1y2_r <= p1y1_r;

      d_r    <= d_nxt;
      n_r    <= n_nxt;
      m_r    <= m_nxt;
      ux3_r  <= ux2_r;
      uy3_r  <= uy2_r;
      p1x3_r <= p1x2_r;
      p1y3_r <= p1y2_r;

      hit4_r  <= hit4_nxt;
      dmag4_r <= dmag4_nxt;
      nmag_r  <= nmag_nxt;
      uxmag_r <= uxmag_nxt;
      uymag_r <= uymag_nxt;
      negx4_r <= negx4_nxt;
      negy4_r <= negy4_nxt;
      p1x4_r  <= p1x3_r;
      p1y4_r  <= p1y3_r;

      pxl_r   <= pxl_nxt;
      pxh_r   <= pxh_nxt;
      pyl_r   <= pyl_nxt;
      pyh_r   <= pyh_nxt;
      hit5_r  <= hit4_r;
      negx5_r <= negx4_r;
      negy5_r <= negy4_r;
      dmag5_r <= dmag4_r;
      p1x5_r  <= p1x4_r;
      p1y5_r  <= p1y4_r;

      cell_r <= cell_nxt;
    end
  end

  always_comb begin
    cell_o     = cell_r;
    cell_o.vld = vld_r[5];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sid_div_cell.sv -----
`default_nettype none

module sid_div_cell
  import sid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire sid_cell_t cell_i,
  output sid_cell_t      cell_o
);

  sid_cell_t   cell_r, cell_nxt;
  logic        vld_r;
  logic [MW:0] tx, ty, dx, dy, dext;
  logic        qx, qy;

  // one restoring step per axis: shift in the next dividend bit, try to subtract
  always_comb begin
    dext = {1'b0, cell_i.dmag};
    tx   = {cell_i.remx, cell_i.lqx[QB-1]};
    ty   = {cell_i.remy, cell_i.lqy[QB-1]};
    dx   = tx - dext;
    dy   = ty - dext;
    qx   = tx >= dext;
    qy   = ty >= dext;
    cell_nxt      = cell_i;
    cell_nxt.remx = qx ? dx[MW-1:0] : tx[MW-1:0];
    cell_nxt.remy = qy ? dy[MW-1:0] : ty[MW-1:0];
    cell_nxt.lqx  = {cell_i.lqx[QB-2:0], qx};
    cell_nxt.lqy  = {cell_i.lqy[QB-2:0], qy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= cell_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  always_comb begin
    cell_o     = cell_r;
    cell_o.vld = vld_r;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/segment_intersect_2d.sv -----
`default_nettype none

// 2d segment intersection test, one segment pair per word
//
// in_*  : one word holds segment a (start, end) and segment b (start, end),
//         signed q7.8 coordinates; taken on a clock edge with in_valid high
//         and in_stall low
// out_* : one word per input word: hit flag and crossing point, the point
//         reads zero when there is no hit; taken when out_valid is high and
//         out_stall is low
// cfg_* : write port for the parallel tolerance, always ready; write it only
//         while no words are in flight
//
// pipeline: 6 front stages, 16 divider cells and 1 output register lie between
// the edge that took the input word and out_valid rising
// throughput: one word per cycle while not stalled, set by the front pipeline
// and the divider cell chain, each cell resolving one quotient bit for both axes
// stall: a word held in the output register with out_stall high freezes the
// whole pipeline, and in_stall is high for exactly that time
// reset: synchronous, drops every in-flight word and sets the tolerance to 0
module segment_intersect_2d
  import sid_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire sid_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output sid_out_t     out_data,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire [TW-1:0] cfg_data
);

  logic [TW-1:0] tol_r;
  logic          en;
  sid_cell_t     chain [QB+1];
  sid_cell_t     last;
  logic          out_valid_r;
  sid_out_t      out_data_r, out_data_nxt;
  logic [CW-1:0] offx, offy;

  // pipeline moves unless the output word is held by the receiver
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  // front: differences, cross products, parallel and range checks, dividends
  sid_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .in_data(in_data),
    .tol    (tol_r),
    .cell_o (chain[0])
  );

  // divider chain: |u|*|n| / |d| per axis, one quotient bit per cell
  for (genvar i = 0; i < QB; i++) begin : g_cell
    sid_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .cell_i(chain[i]),
      .cell_o(chain[i+1])
    );
  end

  // apply the sign to the truncated quotient and offset from the start point
  always_comb begin
    last = chain[QB];
    offx = last.negx ? ({CW{1'b0}} - last.lqx) : last.lqx;
    offy = last.negy ? ({CW{1'b0}} - last.lqy) : last.lqy;
    out_data_nxt.hit     = last.hit;
    out_data_nxt.cross_x = last.hit ? (last.p1x + offx) : '0;
    out_data_nxt.cross_y = last.hit ? (last.p1y + offy) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sid_chk.sv -----
`default_nettype none

module sid_chk
  import sid_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire sid_out_t out_data
);

  // a miss carries no point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.cross_x == '0 && out_data.cross_y == '0)
    else $error("miss word with nonzero point");

  // a blocked output word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("blocked output word changed");

  // input is only stalled by a blocked output word
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind segment_intersect_2d sid_chk u_sid_chk (.*);

`default_nettype wire

// ----- tb/sv/tb_segment_intersect_2d.sv -----
`default_nettype none

module tb_segment_intersect_2d;
  import sid_pkg::*;

  // random part: chunks of words, each chunk under its own tolerance
  localparam int RANDOM_CHUNKS = 6;
  localparam int CHUNK_WORDS   = 250;
  // longer than the input to output latency
  localparam int SETTLE_CYCLES = 30;
  // long receiver hold, well past the pipeline depth
  localparam int HOLD_CYCLES   = 200;
  // percent chance that a side idles, per cycle for the receiver and per word for the sender
  localparam int IDLE_PERCENT  = 6;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  sid_in_t       in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  sid_out_t      out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [TW-1:0] cfg_data  = '0;

  // tolerance as the block should hold it, starts at its reset value
  logic [TW-1:0] cur_tolerance = '0;
  // crossings predicted for accepted words, oldest first
  sid_out_t      pending_crossings[$];
  sid_out_t      expected_word;
  int            mismatch_count = 0;

  // idle switches, changed only at rising edges, and the receiver hold counter, which counts down at falling edges
  bit            tx_idle_on   = 1'b1;
  bit            rx_idle_on   = 1'b1;
  int            rx_hold_left = 0;

  segment_intersect_2d dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // crossing predictor
  // ---------------------------------------------------------------------------

  // parameter x/d lies in [0,1], tested by sign and magnitude, no division
  function automatic bit within_unit(longint x, longint d);
    if (d > 0) return (x >= 0) && (x <= d);
    return (x <= 0) && (x >= d);
  endfunction

  function automatic sid_out_t predict_crossing(sid_in_t s, logic [TW-1:0] tol);
    longint   p1x, p1y, ux, uy, vx, vy, wx, wy;
    longint   den, den_mag, num_a, num_b, pos;
    sid_out_t r;
    // fields are signed, so the casts sign extend
    p1x = longint'(s.a_start_x);
    p1y = longint'(s.a_start_y);
    ux  = longint'(s.a_end_x) - p1x;
    uy  = longint'(s.a_end_y) - p1y;
    vx  = longint'(s.b_end_x) - longint'(s.b_start_x);
    vy  = longint'(s.b_end_y) - longint'(s.b_start_y);
    wx  = p1x - longint'(s.b_start_x);
    wy  = p1y - longint'(s.b_start_y);
    // all cross products in q18.16, at most 35 bits here
    den   = ux * vy - uy * vx;
    num_a = vx * wy - vy * wx;
    num_b = ux * wy - uy * wx;
    r = '0;
    den_mag = (den < 0) ? -den : den;
    // near parallel and collinear pairs never hit
    if (den_mag <= longint'(tol)) return r;
    if (!within_unit(num_a, den) || !within_unit(num_b, den)) return r;
    r.hit = 1'b1;
    // longint division truncates toward zero, same as the block's quotient
    pos = p1x + (ux * num_a) / den;
    r.cross_x = pos[CW-1:0];
    pos = p1y + (uy * num_a) / den;
    r.cross_y = pos[CW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stall, or a long hold when a test asks for one
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= rx_idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // result checker, compares each taken word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_crossings.size() == 0) begin
        $error("result word with nothing expected: hit %0d cross_x %0d cross_y %0d",
               out_data.hit, out_data.cross_x, out_data.cross_y);
        mismatch_count++;
      end else begin
        expected_word = pending_crossings.pop_front();
        if (out_data.hit !== expected_word.hit) begin
          $error("hit: expected %0d actual %0d", expected_word.hit, out_data.hit);
          mismatch_count++;
        end
        if (out_data.cross_x !== expected_word.cross_x) begin
          $error("cross_x: expected %0d actual %0d", expected_word.cross_x, out_data.cross_x);
          mismatch_count++;
        end
        if (out_data.cross_y !== expected_word.cross_y) begin
          $error("cross_y: expected %0d actual %0d", expected_word.cross_y, out_data.cross_y);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving helpers
  // ---------------------------------------------------------------------------

  // offer one segment pair, returns at the rising edge that takes it
  task automatic send_pair(input sid_in_t item);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) ? 1 : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // payload holds while stalled
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_crossings.insert(pending_crossings.size(), predict_crossing(item, cur_tolerance));
  endtask

  // drop valid and wait for every predicted crossing to come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic set_parallel_tolerance(input logic [TW-1:0] tol);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tol;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cur_tolerance = tol;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sid_in_t pair_of(int ax0, int ay0, int ax1, int ay1,
                                      int bx0, int by0, int bx1, int by1);
    sid_in_t item;
    item.a_start_x = ax0[CW-1:0];
    item.a_start_y = ay0[CW-1:0];
    item.a_end_x   = ax1[CW-1:0];
    item.a_end_y   = ay1[CW-1:0];
    item.b_start_x = bx0[CW-1:0];
    item.b_start_y = by0[CW-1:0];
    item.b_end_x   = bx1[CW-1:0];
    item.b_end_y   = by1[CW-1:0];
    return item;
  endfunction

  function automatic int rand_in(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // mostly pairs built to cross, plus parallel pairs, tight clusters and raw noise
  function automatic sid_in_t random_pair();
    int                   kind, lim, cx, cy, ax, ay, bx, by, sa, sb;
    logic signed [CW-1:0] t;
    sid_in_t              item;
    kind = $urandom_range(0, 99);
    cx = rand_in(16383);
    cy = rand_in(16383);
    if (kind < 60) begin
      // both segments pass near a common point, ends at uneven distances
      case ($urandom_range(0, 2))
        0:       lim = 64;
        1:       lim = 1024;
        default: lim = 16383;
      endcase
      ax = rand_in(lim);
      ay = rand_in(lim);
      bx = rand_in(lim);
      by = rand_in(lim);
      sa = $urandom_range(0, 3);
      sb = $urandom_range(0, 3);
      item = pair_of(cx - ax, cy - ay, cx + (ax >>> sa), cy + (ay >>> sa),
                     cx - bx, cy - by, cx + (bx >>> sb), cy + (by >>> sb));
      if ($urandom_range(0, 1)) begin
        t = item.a_start_x; item.a_start_x = item.a_end_x; item.a_end_x = t;
        t = item.a_start_y; item.a_start_y = item.a_end_y; item.a_end_y = t;
      end
      if ($urandom_range(0, 1)) begin
        t = item.b_start_x; item.b_start_x = item.b_end_x; item.b_end_x = t;
        t = item.b_start_y; item.b_start_y = item.b_end_y; item.b_end_y = t;
      end
    end else if (kind < 72) begin
      // parallel pairs, collinear when the offset is zero
      ax = rand_in(4096);
      ay = rand_in(4096);
      bx = rand_in(64);
      by = rand_in(64);
      if ($urandom_range(0, 3) == 0) begin
        bx = 0;
        by = 0;
      end
      sa = $urandom_range(0, 1) ? 1 : -1;
      item = pair_of(cx, cy, cx + ax, cy + ay,
                     cx + bx, cy + by, cx + bx + sa * ax, cy + by + sa * ay);
    end else if (kind < 86) begin
      // short segments in one spot, denominators around the tolerance range
      item = pair_of(cx + rand_in(128), cy + rand_in(128), cx + rand_in(128), cy + rand_in(128),
                     cx + rand_in(128), cy + rand_in(128), cx + rand_in(128), cy + rand_in(128));
    end else begin
      // raw words, every coordinate bit free
      item = sid_in_t'({$urandom, $urandom, $urandom, $urandom});
    end
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, touching ends, parallel and degenerate cases at tolerance 0
  task automatic test_directed();
    // plain x through the origin with d negative, then with b reversed so d goes positive
    send_pair(pair_of(-256, -256, 256, 256, -256, 256, 256, -256));
    send_pair(pair_of(-256, -256, 256, 256, 256, -256, -256, 256));
    // every coordinate at the bottom, then at the top
    send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    // full span diagonals and full span axes
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_of(32767, 0, -32768, 0, 0, 32767, 0, -32768));
    send_pair(pair_of(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
    // a's start on b, a's end on b
    send_pair(pair_of(0, 0, 512, 0, 0, -256, 0, 256));
    send_pair(pair_of(-512, 0, 0, 0, 0, -256, 0, 256));
    // b's start on a, b's end on a
    send_pair(pair_of(-256, 0, 256, 0, 0, 0, 0, 256));
    send_pair(pair_of(-256, 0, 256, 0, 0, 256, 0, 0));
    // shared corner
    send_pair(pair_of(0, 0, 256, 256, 256, 256, 512, 0));
    // one step past a's end
    send_pair(pair_of(-256, 0, 256, 0, 257, -256, 257, 256));
    // parallel offset, collinear overlap
    send_pair(pair_of(0, 0, 256, 0, 0, 256, 256, 256));
    send_pair(pair_of(0, 0, 512, 0, 256, 0, 768, 0));
    // zero length segments
    send_pair(pair_of(100, 100, 100, 100, 0, 0, 256, 256));
    send_pair(pair_of(100, 100, 100, 100, 100, 100, 100, 100));
    // fractional crossing, truncation toward zero on both signs
    send_pair(pair_of(0, 0, -1000, -333, -300, 100, -300, -500));
    send_pair(pair_of(0, 0, 1000, 333, 300, -100, 300, 500));
    // almost parallel, |d| = 512
    send_pair(pair_of(0, 0, 256, 1, 0, 1, 256, 0));
    // alternating bit patterns
    send_pair(sid_in_t'({4{32'h5555_aaaa}}));
    send_pair(sid_in_t'({4{32'haaaa_5555}}));
    drain_results();
  endtask

  // words with |d| right at the tolerance, on both sides of it
  task automatic test_tolerance_edges();
    logic [TW-1:0] tol_list[4];
    tol_list = '{TW'(512), TW'(511), TW'(65535), TW'(65534)};
    foreach (tol_list[i]) begin
      set_parallel_tolerance(tol_list[i]);
      // |d| = 512
      send_pair(pair_of(0, 0, 256, 1, 0, 1, 256, 0));
      // |d| = 65535
      send_pair(pair_of(-128, 0, 129, 0, 0, -127, 0, 128));
      // |d| = 65536
      send_pair(pair_of(-128, 0, 128, 0, 0, -128, 0, 128));
      repeat (3) send_pair(random_pair());
      drain_results();
    end
  endtask

  // receiver holds off long enough that the pipeline fills and the input stalls
  task automatic test_backpressure();
    set_parallel_tolerance(TW'(0));
    rx_hold_left = HOLD_CYCLES;
    repeat (80) send_pair(random_pair());
    drain_results();
  endtask

  // sender stops until the pipeline has emptied, then resumes
  task automatic test_sender_pause();
    repeat (30) send_pair(random_pair());
    drain_results();
    repeat (30) send_pair(random_pair());
    drain_results();
  endtask

  // bulk random words, tolerance changed between chunks
  task automatic test_random();
    logic [TW-1:0] tol;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      case (chunk)
        0:       tol = TW'(65535);
        1:       tol = TW'(1);
        2:       tol = TW'($urandom_range(2, 1023));
        3:       tol = TW'($urandom_range(1024, 65534));
        4:       tol = TW'(0);
        default: tol = TW'($urandom_range(0, 4095));
      endcase
      set_parallel_tolerance(tol);
      // one chunk runs back to back with no idling on either side
      if (chunk == 4) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      repeat (CHUNK_WORDS) send_pair(random_pair());
      drain_results();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_tolerance_edges();
    test_backpressure();
    test_sender_pause();
    test_random();

    // let any stray word show up before the verdict
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_crossings.size() != 0) begin
      $error("%0d predicted crossings never came out", pending_crossings.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
